[hw/rtl/quadrature_position_velocity_accel_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the quadrature position / velocity / acceleration block
// Concurrent checks, compiled out under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_POSITION_VELOCITY_ACCEL_MACROS_SVH
`define QUADRATURE_POSITION_VELOCITY_ACCEL_MACROS_SVH

`ifndef SYNTHESIS

`define QPVA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qpva: check failed");

`define QPVA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("qpva: check failed");

`else

`define QPVA_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define QPVA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hw/rtl/qpva_pkg.sv]
// ----------------------------------------------------------------------------
// qpva_pkg
// Widths, constants, control word and microcode program of the estimator.
// ----------------------------------------------------------------------------
package qpva_pkg;

    localparam int CNT_W   = 16;
    localparam int TIME_W  = 32;
    localparam int SCALE_W = 32;
    localparam int OUT_W   = 16;
    localparam int DIFF_W  = 19;
    localparam int MAG_W   = 16;
    localparam int FRAC_W  = 24;

    localparam logic [SCALE_W-1:0] SCALE_RST = 32'd1966105;

    localparam logic signed [DIFF_W-1:0] CNT_PERIOD = 19'sd65536;
    localparam logic signed [DIFF_W-1:0] CNT_HALF   = 19'sd32768;

    localparam int USEC_W = 20;
    localparam logic [USEC_W-1:0] USEC = 20'd1000000;

    // shared multiplier
    localparam int MA_W   = 48;
    localparam int MB_W   = USEC_W;
    localparam int PROD_W = MA_W + MB_W;

    // velocity / acceleration
    localparam int VEL_W = 32;
    localparam int VQ_W  = 44;
    localparam int AQ_W  = 52;
    localparam logic [VEL_W-2:0] VMAX = '1;

    // divider
    localparam int REM_W  = TIME_W + FRAC_W;
    localparam int DVD_W  = PROD_W;
    localparam int ITER_W = 6;

    // sequencer
    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] ST_WAIT  = 4'd0;
    localparam logic [STEP_W-1:0] ST_MPOS  = 4'd1;
    localparam logic [STEP_W-1:0] ST_MMAG  = 4'd2;
    localparam logic [STEP_W-1:0] ST_MUSEC = 4'd3;
    localparam logic [STEP_W-1:0] ST_DVLD  = 4'd4;
    localparam logic [STEP_W-1:0] ST_DVRUN = 4'd5;
    localparam logic [STEP_W-1:0] ST_VCAP  = 4'd6;
    localparam logic [STEP_W-1:0] ST_DVCAP = 4'd7;
    localparam logic [STEP_W-1:0] ST_MACC  = 4'd8;
    localparam logic [STEP_W-1:0] ST_DALD  = 4'd9;
    localparam logic [STEP_W-1:0] ST_DARUN = 4'd10;
    localparam logic [STEP_W-1:0] ST_ACAP  = 4'd11;
    localparam logic [STEP_W-1:0] ST_ZERO  = 4'd12;
    localparam logic [STEP_W-1:0] ST_EMIT  = 4'd13;

    localparam logic [1:0] ASEL_DS    = 2'd0;
    localparam logic [1:0] ASEL_PROD  = 2'd1;
    localparam logic [1:0] ASEL_DVMAG = 2'd2;

    localparam logic [1:0] BSEL_COUNT = 2'd0;
    localparam logic [1:0] BSEL_MAG   = 2'd1;
    localparam logic [1:0] BSEL_USEC  = 2'd2;

    localparam logic [1:0] DLD_NONE = 2'd0;
    localparam logic [1:0] DLD_VEL  = 2'd1;
    localparam logic [1:0] DLD_ACC  = 2'd2;

    localparam logic [2:0] JC_NEXT     = 3'd0;
    localparam logic [2:0] JC_ALWAYS   = 3'd1;
    localparam logic [2:0] JC_NO_IN    = 3'd2;
    localparam logic [2:0] JC_DT_ZERO  = 3'd3;
    localparam logic [2:0] JC_DIV_BUSY = 3'd4;
    localparam logic [2:0] JC_OUT_FULL = 3'd5;

    typedef struct packed {
        logic              take_in;
        logic              mul_en;
        logic [1:0]        a_sel;
        logic [1:0]        b_sel;
        logic              pos_cap;
        logic [1:0]        div_ld;
        logic              vel_cap;
        logic              dv_cap;
        logic              acc_cap;
        logic              zero_cap;
        logic              emit;
        logic [2:0]        cond;
        logic [STEP_W-1:0] target;
        logic              last;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic dt_zero;
        logic div_busy;
        logic out_full;
    } stat_t;

    typedef struct packed {
        logic              load;
        logic [REM_W-1:0]  rem;
        logic [DVD_W-1:0]  dvd;
        logic [REM_W-1:0]  dvs;
        logic [ITER_W-1:0] iters;
    } div_ld_t;

    function automatic ctrl_t qpva_ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        begin
            w = '0;
            unique case (step)
                ST_WAIT:
                begin
                    w.take_in = 1'b1;
                    w.cond    = JC_NO_IN;
                    w.target  = ST_WAIT;
                end
                ST_MPOS:
                begin
                    w.mul_en = 1'b1;
                    w.a_sel  = ASEL_DS;
                    w.b_sel  = BSEL_COUNT;
                end
                ST_MMAG:
                begin
                    w.pos_cap = 1'b1;
                    w.mul_en  = 1'b1;
                    w.a_sel   = ASEL_DS;
                    w.b_sel   = BSEL_MAG;
                    w.cond    = JC_DT_ZERO;
                    w.target  = ST_ZERO;
                end
                ST_MUSEC:
                begin
                    w.mul_en = 1'b1;
                    w.a_sel  = ASEL_PROD;
                    w.b_sel  = BSEL_USEC;
                end
                ST_DVLD:
                begin
                    w.div_ld = DLD_VEL;
                end
                ST_DVRUN:
                begin
                    w.cond   = JC_DIV_BUSY;
                    w.target = ST_DVRUN;
                end
                ST_VCAP:
                begin
                    w.vel_cap = 1'b1;
                end
                ST_DVCAP:
                begin
                    w.dv_cap = 1'b1;
                end
                ST_MACC:
                begin
                    w.mul_en = 1'b1;
                    w.a_sel  = ASEL_DVMAG;
                    w.b_sel  = BSEL_USEC;
                end
                ST_DALD:
                begin
                    w.div_ld = DLD_ACC;
                end
                ST_DARUN:
                begin
                    w.cond   = JC_DIV_BUSY;
                    w.target = ST_DARUN;
                end
                ST_ACAP:
                begin
                    w.acc_cap = 1'b1;
                    w.cond    = JC_ALWAYS;
                    w.target  = ST_EMIT;
                end
                ST_ZERO:
                begin
                    w.zero_cap = 1'b1;
                end
                ST_EMIT:
                begin
                    w.emit   = 1'b1;
                    w.cond   = JC_OUT_FULL;
                    w.target = ST_EMIT;
                    w.last   = 1'b1;
                end
                default:
                begin
                    w.cond   = JC_ALWAYS;
                    w.target = ST_WAIT;
                end
            endcase
            return w;
        end
    endfunction

endpackage

[hw/rtl/qpva_if.sv]
// ----------------------------------------------------------------------------
// qpva channel interfaces
// Sample and result channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface qpva_smp_if;
    import qpva_pkg::*;

    logic              valid;
    logic              ready;
    logic [CNT_W-1:0]  count;
    logic [TIME_W-1:0] time_us;

    modport source (output valid, output count, output time_us, input ready);
    modport sink   (input valid, input count, input time_us, output ready);
endinterface

interface qpva_res_if;
    import qpva_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] position;
    logic signed [OUT_W-1:0] velocity;
    logic signed [OUT_W-1:0] acceleration;
    logic                    zero_interval;

    modport source (output valid, output position, output velocity, output acceleration,
                    output zero_interval, input ready);
    modport sink   (input valid, input position, input velocity, input acceleration,
                    input zero_interval, output ready);
endinterface

[hw/rtl/quadrature_position_velocity_accel.sv]
// ----------------------------------------------------------------------------
// quadrature_position_velocity_accel
// Encoder sample in, position / velocity / acceleration out, microcoded.
//
//   channel   dir  beat
//   sample    in   count, time_us
//   result    out  position, velocity, acceleration, zero_interval
//   cfg       in   distance_scale write (cfg_wr_en / cfg_wr_data)
//
// The shared radix-2 divider runs 44 velocity and 52 acceleration iterations
// per beat; both divisions are skipped when the timestamp has not moved.
// One sample in flight; the next is taken once its result sits in the output
// register, so a stalled result only holds back the following emit.
// Reset is asynchronous; history clears to zero, scale to its default.
// ----------------------------------------------------------------------------
`include "quadrature_position_velocity_accel_macros.svh"

module quadrature_position_velocity_accel (
    input  logic                          clk,
    input  logic                          rst_n,
    qpva_smp_if.sink                      sample,
    qpva_res_if.source                    result,
    input  logic                          cfg_wr_en,
    input  logic [qpva_pkg::SCALE_W-1:0]  cfg_wr_data
);
    import qpva_pkg::*;

    ctrl_t             ctrl;
    stat_t             stat;
    div_ld_t           div_ld;
    logic [STEP_W-1:0] step;
    logic              div_busy;
    logic [DVD_W-1:0]  div_quo;
    logic              dt_zero;
    logic              out_full;
    logic              accept;
    logic              res_valid;
    logic [OUT_W-1:0]  res_vel;
    logic [OUT_W-1:0]  res_acc;
    logic              res_zero;

    assign accept       = sample.valid && ctrl.take_in;
    assign sample.ready = ctrl.take_in;

    assign stat.in_valid = sample.valid;
    assign stat.dt_zero  = dt_zero;
    assign stat.div_busy = div_busy;
    assign stat.out_full = out_full;

    qpva_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl),
        .step  (step)
    );

    qpva_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ld    (div_ld),
        .busy  (div_busy),
        .quo   (div_quo)
    );

    qpva_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctrl             (ctrl),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .accept           (accept),
        .smp_count        (sample.count),
        .smp_time_us      (sample.time_us),
        .div_quo          (div_quo),
        .div_ld           (div_ld),
        .dt_zero          (dt_zero),
        .out_full         (out_full),
        .res_ready        (result.ready),
        .res_valid        (res_valid),
        .res_position     (result.position),
        .res_velocity     (res_vel),
        .res_acceleration (res_acc),
        .res_zero         (res_zero)
    );

    assign result.valid         = res_valid;
    assign result.velocity      = $signed(res_vel);
    assign result.acceleration  = $signed(res_acc);
    assign result.zero_interval = res_zero;

    `QPVA_ASSERT_IMP(a_div_in_run, clk, rst_n, div_busy, step == ST_DVRUN || step == ST_DARUN)
    `QPVA_ASSERT_IMP(a_zero_rates, clk, rst_n, res_valid && res_zero, res_vel == '0 && res_acc == '0)
    `QPVA_ASSERT_NEXT(a_one_in_flight, clk, rst_n, accept, !ctrl.take_in)
    `QPVA_ASSERT_NEXT(a_emit_shows, clk, rst_n, ctrl.emit && !out_full, res_valid)

endmodule

[hw/rtl/qpva_div.sv]
// ----------------------------------------------------------------------------
// qpva_div
// Radix-2 restoring divider, one quotient bit per cycle, preloadable remainder.
// ----------------------------------------------------------------------------
module qpva_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  qpva_pkg::div_ld_t               ld,
    output logic                            busy,
    output logic [qpva_pkg::DVD_W-1:0]      quo
);
    import qpva_pkg::*;

    logic [ITER_W-1:0] iters_reg;
    logic [ITER_W-1:0] iters_next;
    logic [REM_W-1:0]  rem_reg;
    logic [REM_W-1:0]  rem_next;
    logic [DVD_W-1:0]  sreg_reg;
    logic [DVD_W-1:0]  sreg_next;
    logic [REM_W-1:0]  dvs_reg;
    logic [REM_W:0]    rem_sh;
    logic [REM_W:0]    rem_sub;
    logic              ge;

    assign busy = (iters_reg != '0);
    assign quo  = sreg_reg;

    always_comb
    begin
        rem_sh     = {rem_reg, sreg_reg[DVD_W-1]};
        rem_sub    = rem_sh - {1'b0, dvs_reg};
        ge         = (rem_sh >= {1'b0, dvs_reg});
        rem_next   = ge ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
        sreg_next  = {sreg_reg[DVD_W-2:0], ge};
        iters_next = iters_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iters_reg <= '0;
        end
        else if (ld.load)
        begin
            iters_reg <= ld.iters;
        end
        else if (busy)
        begin
            iters_reg <= iters_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld.load)
        begin
            rem_reg  <= ld.rem;
            sreg_reg <= ld.dvd;
            dvs_reg  <= ld.dvs;
        end
        else if (busy)
        begin
            rem_reg  <= rem_next;
            sreg_reg <= sreg_next;
        end
    end

endmodule

[hw/rtl/qpva_seq.sv]
// ----------------------------------------------------------------------------
// qpva_seq
// Step counter and microcode ROM; conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module qpva_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  qpva_pkg::stat_t              stat,
    output qpva_pkg::ctrl_t              ctrl,
    output logic [qpva_pkg::STEP_W-1:0]  step
);
    import qpva_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              taken;

    assign ctrl = qpva_ucode(step_reg);
    assign step = step_reg;

    always_comb
    begin
        unique case (ctrl.cond)
            JC_NEXT:     taken = 1'b0;
            JC_ALWAYS:   taken = 1'b1;
            JC_NO_IN:    taken = !stat.in_valid;
            JC_DT_ZERO:  taken = stat.dt_zero;
            JC_DIV_BUSY: taken = stat.div_busy;
            JC_OUT_FULL: taken = stat.out_full;
            default:     taken = 1'b1;
        endcase

        if (taken)
        begin
            step_next = ctrl.target;
        end
        else if (ctrl.last)
        begin
            step_next = ST_WAIT;
        end
        else
        begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

[hw/rtl/qpva_dp.sv]
// ----------------------------------------------------------------------------
// qpva_dp
// Datapath: sample capture, count unwrap, shared multiplier, divider load,
// velocity saturation, result and history registers, output register.
// ----------------------------------------------------------------------------
module qpva_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  qpva_pkg::ctrl_t                     ctrl,
    input  logic                                cfg_wr_en,
    input  logic [qpva_pkg::SCALE_W-1:0]        cfg_wr_data,
    input  logic                                accept,
    input  logic [qpva_pkg::CNT_W-1:0]          smp_count,
    input  logic [qpva_pkg::TIME_W-1:0]         smp_time_us,
    input  logic [qpva_pkg::DVD_W-1:0]          div_quo,
    output qpva_pkg::div_ld_t                   div_ld,
    output logic                                dt_zero,
    output logic                                out_full,
    input  logic                                res_ready,
    output logic                                res_valid,
    output logic signed [qpva_pkg::OUT_W-1:0]   res_position,
    output logic signed [qpva_pkg::OUT_W-1:0]   res_velocity,
    output logic signed [qpva_pkg::OUT_W-1:0]   res_acceleration,
    output logic                                res_zero
);
    import qpva_pkg::*;

    // configuration and history
    logic [SCALE_W-1:0] ds_reg;
    logic [CNT_W-1:0]   prev_count_reg;
    logic [TIME_W-1:0]  prev_time_reg;
    logic [VEL_W-1:0]   prev_vel_reg;
    logic               res_valid_reg;
    logic               res_valid_next;

    // per-beat working registers
    logic [CNT_W-1:0]   count_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [TIME_W-1:0]  dt_reg;
    logic [MAG_W-1:0]   mag_reg;
    logic               dneg_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [OUT_W-1:0]   pos_reg;
    logic [OUT_W-1:0]   vel_reg;
    logic [OUT_W-1:0]   acc_reg;
    logic [VEL_W-1:0]   vsat_reg;
    logic [VEL_W-1:0]   dvmag_reg;
    logic               dvneg_reg;
    logic               zflag_reg;

    // output register
    logic [OUT_W-1:0]   out_pos_reg;
    logic [OUT_W-1:0]   out_vel_reg;
    logic [OUT_W-1:0]   out_acc_reg;
    logic               out_zero_reg;

    logic signed [DIFF_W-1:0] d0;
    logic signed [DIFF_W-1:0] d1;
    logic signed [DIFF_W-1:0] d2;
    logic signed [DIFF_W-1:0] d_abs;
    logic [MA_W-1:0]          a_mux;
    logic [MB_W-1:0]          b_mux;
    logic [PROD_W-1:0]        mul_p;
    logic [VEL_W-2:0]         sat_mag;
    logic [VEL_W:0]           dv;
    logic [VEL_W:0]           dv_neg;
    logic                     emit_fire;

    // count unwrap
    always_comb
    begin
        d0    = $signed({3'b000, prev_count_reg}) - $signed({3'b000, smp_count});
        d1    = (d0 > CNT_HALF) ? d0 - CNT_PERIOD : d0;
        d2    = (d1 < -CNT_HALF) ? d1 + CNT_PERIOD : d1;
        d_abs = d2[DIFF_W-1] ? -d2 : d2;
    end

    // shared multiplier
    always_comb
    begin
        unique case (ctrl.a_sel)
            ASEL_DS:    a_mux = MA_W'(ds_reg);
            ASEL_PROD:  a_mux = prod_reg[MA_W-1:0];
            ASEL_DVMAG: a_mux = MA_W'(dvmag_reg);
            default:    a_mux = '0;
        endcase
        unique case (ctrl.b_sel)
            BSEL_COUNT: b_mux = MB_W'(count_reg);
            BSEL_MAG:   b_mux = MB_W'(mag_reg);
            BSEL_USEC:  b_mux = USEC;
            default:    b_mux = '0;
        endcase
        mul_p = PROD_W'(a_mux) * PROD_W'(b_mux);
    end

    // velocity saturation and velocity change
    always_comb
    begin
        sat_mag = (|div_quo[VQ_W-1:VEL_W-1]) ? VMAX : div_quo[VEL_W-2:0];
        dv      = {vsat_reg[VEL_W-1], vsat_reg} - {prev_vel_reg[VEL_W-1], prev_vel_reg};
        dv_neg  = '0 - dv;
    end

    // divider load
    always_comb
    begin
        div_ld = '0;
        unique case (ctrl.div_ld)
            DLD_VEL:
            begin
                div_ld.load  = 1'b1;
                div_ld.rem   = REM_W'(prod_reg[PROD_W-1:VQ_W]);
                div_ld.dvd   = {prod_reg[VQ_W-1:0], {(DVD_W-VQ_W){1'b0}}};
                div_ld.dvs   = {dt_reg, {FRAC_W{1'b0}}};
                div_ld.iters = ITER_W'(VQ_W);
            end
            DLD_ACC:
            begin
                div_ld.load  = 1'b1;
                div_ld.rem   = '0;
                div_ld.dvd   = {prod_reg[AQ_W-1:0], {(DVD_W-AQ_W){1'b0}}};
                div_ld.dvs   = REM_W'(dt_reg);
                div_ld.iters = ITER_W'(AQ_W);
            end
            default:
            begin
                div_ld.load = 1'b0;
            end
        endcase
    end

    assign dt_zero   = (dt_reg == '0);
    assign out_full  = res_valid_reg && !res_ready;
    assign emit_fire = ctrl.emit && !out_full;

    always_comb
    begin
        if (emit_fire)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ds_reg         <= SCALE_RST;
            prev_count_reg <= '0;
            prev_time_reg  <= '0;
            prev_vel_reg   <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                ds_reg <= cfg_wr_data;
            end
            if (emit_fire)
            begin
                prev_count_reg <= count_reg;
                prev_time_reg  <= time_reg;
                prev_vel_reg   <= vsat_reg;
            end
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            count_reg <= smp_count;
            time_reg  <= smp_time_us;
            dt_reg    <= smp_time_us - prev_time_reg;
            mag_reg   <= d_abs[MAG_W-1:0];
            dneg_reg  <= d2[DIFF_W-1];
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= mul_p;
        end
        if (ctrl.pos_cap)
        begin
            pos_reg <= '0 - prod_reg[FRAC_W +: OUT_W];
        end
        if (ctrl.vel_cap)
        begin
            vel_reg   <= dneg_reg ? '0 - div_quo[OUT_W-1:0] : div_quo[OUT_W-1:0];
            vsat_reg  <= dneg_reg ? '0 - {1'b0, sat_mag} : {1'b0, sat_mag};
            zflag_reg <= 1'b0;
        end
        if (ctrl.dv_cap)
        begin
            dvneg_reg <= dv[VEL_W];
            dvmag_reg <= dv[VEL_W] ? dv_neg[VEL_W-1:0] : dv[VEL_W-1:0];
        end
        if (ctrl.acc_cap)
        begin
            acc_reg <= dvneg_reg ? '0 - div_quo[OUT_W-1:0] : div_quo[OUT_W-1:0];
        end
        if (ctrl.zero_cap)
        begin
            vel_reg   <= '0;
            acc_reg   <= '0;
            vsat_reg  <= '0;
            zflag_reg <= 1'b1;
        end
        if (emit_fire)
        begin
            out_pos_reg  <= pos_reg;
            out_vel_reg  <= vel_reg;
            out_acc_reg  <= acc_reg;
            out_zero_reg <= zflag_reg;
        end
    end

    assign res_valid        = res_valid_reg;
    assign res_position     = $signed(out_pos_reg);
    assign res_velocity     = $signed(out_vel_reg);
    assign res_acceleration = $signed(out_acc_reg);
    assign res_zero         = out_zero_reg;

endmodule
